/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the header parser blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");
// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

/* rtl/hhsp_pkg.sv */
// ----------------------------------------------------------------------------
// hhsp_pkg
// Types, syntax table and codes shared by the header parser modules.
// ----------------------------------------------------------------------------
package hhsp_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int POS_W          = 6;
    localparam int QUEUE_DEPTH    = 2;

    // unit kinds
    localparam logic [1:0] KIND_AUD   = 2'd0;
    localparam logic [1:0] KIND_SPS   = 2'd1;
    localparam logic [1:0] KIND_PPS   = 2'd2;
    localparam logic [1:0] KIND_SLICE = 2'd3;

    // element codes
    localparam logic [4:0] K_NONE  = 5'd0;
    localparam logic [4:0] K_UE    = 5'd1;
    localparam logic [4:0] K_SE    = 5'd2;
    localparam logic [4:0] K_FRAME = 5'd3;
    localparam logic [4:0] K_GROUP = 5'd4;
    localparam logic [4:0] K_FIX   = 5'd16;

    // syntax positions
    localparam logic [POS_W-1:0] POS_AUD_TYPE    = 6'd1;
    localparam logic [POS_W-1:0] POS_PROFILE     = 6'd2;
    localparam logic [POS_W-1:0] POS_CONSTR0     = 6'd3;
    localparam logic [POS_W-1:0] POS_SPS_ID      = 6'd9;
    localparam logic [POS_W-1:0] POS_CHROMA      = 6'd10;
    localparam logic [POS_W-1:0] POS_SEP_PLANE   = 6'd11;
    localparam logic [POS_W-1:0] POS_LUMA_DEPTH  = 6'd12;
    localparam logic [POS_W-1:0] POS_SCALE_FLAG  = 6'd15;
    localparam logic [POS_W-1:0] POS_LOG2_FN     = 6'd16;
    localparam logic [POS_W-1:0] POS_POC_TYPE    = 6'd17;
    localparam logic [POS_W-1:0] POS_LOG2_POC    = 6'd18;
    localparam logic [POS_W-1:0] POS_POC_ZERO    = 6'd19;
    localparam logic [POS_W-1:0] POS_NUM_CYCLE   = 6'd22;
    localparam logic [POS_W-1:0] POS_NUM_REF     = 6'd23;
    localparam logic [POS_W-1:0] POS_FRAME_MBS   = 6'd27;
    localparam logic [POS_W-1:0] POS_PPS_ID      = 6'd28;
    localparam logic [POS_W-1:0] POS_PPS_SPS     = 6'd29;
    localparam logic [POS_W-1:0] POS_NUM_GROUPS  = 6'd32;
    localparam logic [POS_W-1:0] POS_MAP_TYPE    = 6'd33;
    localparam logic [POS_W-1:0] POS_CHANGE_DIR  = 6'd34;
    localparam logic [POS_W-1:0] POS_CHANGE_RATE = 6'd35;
    localparam logic [POS_W-1:0] POS_MAP_UNITS   = 6'd36;
    localparam logic [POS_W-1:0] POS_L0_ACTIVE   = 6'd37;
    localparam logic [POS_W-1:0] POS_REDUNDANT   = 6'd46;
    localparam logic [POS_W-1:0] POS_FIRST_MB    = 6'd47;
    localparam logic [POS_W-1:0] POS_SLICE_PPS   = 6'd49;
    localparam logic [POS_W-1:0] POS_COLOUR      = 6'd50;
    localparam logic [POS_W-1:0] POS_FRAME_NUM   = 6'd51;
    localparam logic [POS_W-1:0] P_LIST          = 6'd52;
    localparam logic [POS_W-1:0] P_DELTA         = 6'd53;
    localparam logic [POS_W-1:0] P_REFOFS        = 6'd54;
    localparam logic [POS_W-1:0] P_RUN           = 6'd55;
    localparam logic [POS_W-1:0] P_TLEFT         = 6'd56;
    localparam logic [POS_W-1:0] P_BRIGHT        = 6'd57;
    localparam logic [POS_W-1:0] P_GROUP         = 6'd58;
    localparam logic [POS_W-1:0] P_DONE          = 6'd59;

    localparam logic [5:0] FIELD_SLICE_PPS = 6'(POS_SLICE_PPS - 6'd1);

    // one queued request: a payload byte and how to treat it
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       last;
        logic       drop;
    } hhsp_entry_t;

    function automatic logic [4:0] elem_code(input logic [POS_W-1:0] pos);
        logic [4:0] c;
        case (pos)
            6'd1:                                 c = K_FIX + 5'd3;
            6'd2, 6'd8:                           c = K_FIX + 5'd8;
            6'd7:                                 c = K_FIX + 5'd4;
            6'd40, 6'd50:                         c = K_FIX + 5'd2;
            6'd3, 6'd4, 6'd5, 6'd6, 6'd11, 6'd14, 6'd15, 6'd19, 6'd24, 6'd27,
            6'd30, 6'd31, 6'd34, 6'd39, 6'd44, 6'd45, 6'd46, 6'd52:
                                                  c = K_FIX + 5'd1;
            6'd9, 6'd10, 6'd12, 6'd13, 6'd16, 6'd17, 6'd18, 6'd22, 6'd23,
            6'd25, 6'd26, 6'd28, 6'd29, 6'd32, 6'd33, 6'd35, 6'd36, 6'd37,
            6'd38, 6'd47, 6'd48, 6'd49, 6'd55, 6'd56, 6'd57:
                                                  c = K_UE;
            6'd20, 6'd21, 6'd41, 6'd42, 6'd43, 6'd53, 6'd54:
                                                  c = K_SE;
            6'd51:                                c = K_FRAME;
            6'd58:                                c = K_GROUP;
            default:                              c = K_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [5:0] fixed_bits(input logic [4:0] code);
        return (code >= K_FIX) ? {1'b0, code - K_FIX} : 6'd0;
    endfunction

    function automatic logic [POS_W-1:0] start_pos(input logic [1:0] kind);
        logic [POS_W-1:0] p;
        case (kind)
            KIND_AUD:   p = POS_AUD_TYPE;
            KIND_SPS:   p = POS_PROFILE;
            KIND_PPS:   p = POS_PPS_ID;
            KIND_SLICE: p = POS_FIRST_MB;
            default:    p = POS_AUD_TYPE;
        endcase
        return p;
    endfunction

endpackage

/* rtl/hhsp_front.sv */
// ----------------------------------------------------------------------------
// hhsp_front
// Accepts payload bytes and marks emulation-prevention bytes for dropping.
// ----------------------------------------------------------------------------
module hhsp_front
    import hhsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        q_full,
    output logic        q_push,
    output hhsp_entry_t q_entry
);

    logic [1:0] zero_run_reg;
    logic [1:0] zero_run_next;
    logic       is_epb;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign is_epb   = (zero_run_reg == 2'd2) && (data_byte == 8'h03);

    assign q_entry.op   = op;
    assign q_entry.data = data_byte;
    assign q_entry.last = last_byte;
    assign q_entry.drop = is_epb;

    always_comb
    begin
        if (is_epb)
        begin
            zero_run_next = 2'd0;
        end
        else if (data_byte == 8'h00)
        begin
            zero_run_next = (zero_run_reg == 2'd2) ? 2'd2 : zero_run_reg + 2'd1;
        end
        else
        begin
            zero_run_next = 2'd0;
        end
        // restart the run at each unit boundary
        if (last_byte)
        begin
            zero_run_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg <= 2'd0;
        end
        else if (q_push)
        begin
            zero_run_reg <= zero_run_next;
        end
    end

endmodule

/* rtl/hhsp_queue.sv */
// ----------------------------------------------------------------------------
// hhsp_queue
// Short request queue between the byte front end and the bit parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hhsp_queue
    import hhsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  hhsp_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output logic        valid,
    output hhsp_entry_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    hhsp_entry_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !full)
    `ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, valid)

endmodule

/* rtl/hhsp_back.sv */
// ----------------------------------------------------------------------------
// hhsp_back
// Bit-serial syntax parser with result hold stage and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hhsp_back
    import hhsp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  hhsp_entry_t q_entry,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  field_id,
    output logic [31:0] field_value,
    output logic        bad_reference,
    output logic        code_error,
    output logic        last_in_item
);

    localparam logic [31:0] SAT_UE = 32'((64'd1 << VALUE_BITS) - 64'd1);
    localparam logic [31:0] SAT_SE = 32'((64'd1 << (VALUE_BITS - 1)) - 64'd1);
    localparam logic [5:0]  VB6    = 6'(VALUE_BITS);
    localparam logic [8:0]  VB9    = 9'(VALUE_BITS);

    // parser state
    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [5:0]       pz_reg,   pz_next;
    logic [31:0]      acc_reg,  acc_next;
    logic [5:0]       bl_reg,   bl_next;
    logic [3:0]       list_reg, list_next;
    logic [6:0]       ent_reg,  ent_next;
    logic [7:0]       ls_reg,   ls_next;
    logic [31:0]      loop_reg, loop_next;
    logic [7:0]       flags_reg, flags_next;
    logic [15:0]      pd_sps_id_reg, pd_sps_id_next;
    logic [7:0]       pd_log2_reg, pd_log2_next;
    logic             pd_sep_reg, pd_sep_next;
    logic [15:0]      pd_pps_id_reg, pd_pps_id_next;
    logic [15:0]      pd_pps_sps_reg, pd_pps_sps_next;
    logic [15:0]      ac_sps_id_reg, ac_sps_id_next;
    logic [7:0]       ac_log2_reg, ac_log2_next;
    logic             ac_sep_reg, ac_sep_next;
    logic [15:0]      ac_pps_id_reg, ac_pps_id_next;
    logic [15:0]      ac_pps_sps_reg, ac_pps_sps_next;

    // sequencing, hold stage and output
    logic [2:0]  bit_reg, bit_next;
    logic        flush_reg, flush_next;
    logic        held_valid_reg, held_valid_next;
    logic [5:0]  held_id_reg, held_id_next;
    logic [31:0] held_value_reg, held_value_next;
    logic        held_bad_reg, held_bad_next;
    logic        held_err_reg, held_err_next;
    logic        out_valid_reg, out_valid_next;
    logic [5:0]  id_reg, id_next;
    logic [31:0] value_reg, value_next;
    logic        bad_reg, bad_next;
    logic        err_reg, err_next;
    logic        last_reg, last_next;
    logic        state_we;

    // per-bit datapath
    logic [POS_W-1:0] pos_e;
    logic [7:0]       flags_e;
    logic [5:0]       pz_e;
    logic [31:0]      acc_e;
    logic [5:0]       bl_e;
    logic [4:0]       code;
    logic             b;
    logic             fin;
    logic [31:0]      val;
    logic             err;
    logic [31:0]      acc_src;
    logic [32:0]      m;
    logic [31:0]      h;
    logic [5:0]       s_len;
    logic [POS_W-1:0] nx;
    logic             bad;
    logic             res_v;
    logic [7:0]       ns;
    logic [6:0]       ent_inc;
    logic [3:0]       list_inc;
    logic [POS_W-1:0] list_nx;
    logic [4:0]       nx_code;
    logic [8:0]       fw;
    logic [15:0]      v16;
    logic [7:0]       v8;
    logic             end_of_entry;
    logic             extra;
    logic             out_free;

    assign out_valid     = out_valid_reg;
    assign field_id      = id_reg;
    assign field_value   = value_reg;
    assign bad_reference = bad_reg;
    assign code_error    = err_reg;
    assign last_in_item  = last_reg;

    assign v16 = (val[31:16] != 16'd0) ? 16'hFFFF : val[15:0];
    assign v8  = (val[31:8] != 24'd0) ? 8'hFF : val[7:0];

    always_comb
    begin
        // take the unit kind and first element on the first byte
        if (pos_reg == '0)
        begin
            pos_e   = start_pos(q_entry.op);
            flags_e = {6'd0, q_entry.op};
            pz_e    = 6'd0;
            acc_e   = 32'd0;
            bl_e    = fixed_bits(elem_code(start_pos(q_entry.op)));
        end
        else
        begin
            pos_e   = pos_reg;
            flags_e = flags_reg;
            pz_e    = pz_reg;
            acc_e   = acc_reg;
            bl_e    = bl_reg;
        end

        code = elem_code(pos_e);
        b    = q_entry.data[3'd7 - bit_reg];

        pos_next        = pos_e;
        pz_next         = pz_e;
        acc_next        = acc_e;
        bl_next         = bl_e;
        list_next       = list_reg;
        ent_next        = ent_reg;
        ls_next         = ls_reg;
        loop_next       = loop_reg;
        flags_next      = flags_e;
        pd_sps_id_next  = pd_sps_id_reg;
        pd_log2_next    = pd_log2_reg;
        pd_sep_next     = pd_sep_reg;
        pd_pps_id_next  = pd_pps_id_reg;
        pd_pps_sps_next = pd_pps_sps_reg;
        ac_sps_id_next  = ac_sps_id_reg;
        ac_log2_next    = ac_log2_reg;
        ac_sep_next     = ac_sep_reg;
        ac_pps_id_next  = ac_pps_id_reg;
        ac_pps_sps_next = ac_pps_sps_reg;

        fin     = 1'b0;
        err     = 1'b0;
        val     = 32'd0;
        acc_src = 32'd0;
        bad     = 1'b0;
        nx      = pos_e;

        // consume one bit
        if (!q_entry.drop && code != K_NONE)
        begin
            if (code != K_UE && code != K_SE)
            begin
                acc_next = {acc_e[30:0], b};
                bl_next  = bl_e - 6'd1;
                if (bl_next == 6'd0)
                begin
                    fin = 1'b1;
                    val = acc_next;
                end
            end
            else if (bl_e == 6'd0 && !b)
            begin
                pz_next = pz_e + 6'd1;
                if (pz_next == VB6)
                begin
                    fin = 1'b1;
                    err = 1'b1;
                    val = (code == K_SE) ? SAT_SE : SAT_UE;
                end
            end
            else if (bl_e == 6'd0 && pz_e != 6'd0)
            begin
                bl_next = pz_e;
            end
            else
            begin
                if (bl_e != 6'd0)
                begin
                    acc_next = {acc_e[30:0], b};
                    bl_next  = bl_e - 6'd1;
                    acc_src  = acc_next;
                end
                if (bl_next == 6'd0)
                begin
                    fin = 1'b1;
                end
            end
        end

        m = (33'd1 << pz_e) | {1'b0, acc_src};
        h = m[32:1];
        if (fin && !err)
        begin
            if (code == K_SE)
            begin
                val = m[0] ? (32'd0 - h) : h;
            end
            else if (code == K_UE)
            begin
                val = 32'(m - 33'd1);
            end
        end
        if (err)
        begin
            s_len = VB6;
        end
        else
        begin
            s_len = (acc_src == 32'd0) ? pz_e : pz_e + 6'd1;
        end

        // scaling list stepping
        list_inc = list_reg + 4'd1;
        list_nx  = (list_inc < (flags_e[3] ? 4'd12 : 4'd8)) ? P_LIST : POS_LOG2_FN;
        ns       = ls_reg + val[7:0];
        ent_inc  = ent_reg + 7'd1;

        // pick the next element
        if (fin)
        begin
            case (pos_e)
                POS_AUD_TYPE, POS_FRAME_MBS, POS_REDUNDANT, POS_FRAME_NUM:
                begin
                    nx = P_DONE;
                end
                POS_PROFILE:
                begin
                    if (val == 32'd100 || val == 32'd110 || val == 32'd122
                        || val == 32'd144)
                    begin
                        flags_next = flags_e | 8'd4;
                    end
                    nx = POS_CONSTR0;
                end
                POS_SPS_ID:
                begin
                    pd_sps_id_next = v16;
                    nx = flags_e[2] ? POS_CHROMA : POS_LOG2_FN;
                end
                POS_CHROMA:
                begin
                    if (val == 32'd3)
                    begin
                        flags_next = flags_e | 8'd8;
                        nx = POS_SEP_PLANE;
                    end
                    else
                    begin
                        nx = POS_LUMA_DEPTH;
                    end
                end
                POS_SEP_PLANE:
                begin
                    pd_sep_next = val[0];
                    nx = POS_LUMA_DEPTH;
                end
                POS_SCALE_FLAG:
                begin
                    if (val == 32'd0)
                    begin
                        nx = POS_LOG2_FN;
                    end
                    else
                    begin
                        list_next = 4'd0;
                        nx = P_LIST;
                    end
                end
                P_LIST:
                begin
                    if (val == 32'd0)
                    begin
                        list_next = list_inc;
                        nx = list_nx;
                    end
                    else
                    begin
                        ent_next = 7'd0;
                        ls_next  = 8'd8;
                        nx = P_DELTA;
                    end
                end
                P_DELTA:
                begin
                    if (ns != 8'd0)
                    begin
                        ls_next = ns;
                    end
                    ent_next = ent_inc;
                    if (ns == 8'd0 || ent_inc >= ((list_reg < 4'd6) ? 7'd16 : 7'd64))
                    begin
                        list_next = list_inc;
                        nx = list_nx;
                    end
                    else
                    begin
                        nx = P_DELTA;
                    end
                end
                POS_LOG2_FN:
                begin
                    pd_log2_next = v8;
                    nx = POS_POC_TYPE;
                end
                POS_POC_TYPE:
                begin
                    if (val == 32'd0)
                    begin
                        nx = POS_LOG2_POC;
                    end
                    else if (val == 32'd1)
                    begin
                        nx = POS_POC_ZERO;
                    end
                    else
                    begin
                        nx = POS_NUM_REF;
                    end
                end
                POS_LOG2_POC:
                begin
                    nx = POS_NUM_REF;
                end
                POS_NUM_CYCLE:
                begin
                    if (val == 32'd0)
                    begin
                        nx = POS_NUM_REF;
                    end
                    else
                    begin
                        loop_next = val - 32'd1;
                        nx = P_REFOFS;
                    end
                end
                P_REFOFS:
                begin
                    if (loop_reg == 32'd0)
                    begin
                        nx = POS_NUM_REF;
                    end
                    else
                    begin
                        loop_next = loop_reg - 32'd1;
                        nx = P_REFOFS;
                    end
                end
                POS_PPS_ID:
                begin
                    pd_pps_id_next = v16;
                    nx = POS_PPS_SPS;
                end
                POS_PPS_SPS:
                begin
                    pd_pps_sps_next = v16;
                    nx = pos_e + 6'd1;
                end
                POS_NUM_GROUPS:
                begin
                    flags_next = {s_len, flags_e[1:0]};
                    loop_next  = val;
                    nx = (val != 32'd0) ? POS_MAP_TYPE : POS_L0_ACTIVE;
                end
                POS_MAP_TYPE:
                begin
                    if (val == 32'd0)
                    begin
                        nx = P_RUN;
                    end
                    else if (val == 32'd2)
                    begin
                        loop_next = loop_reg - 32'd1;
                        nx = P_TLEFT;
                    end
                    else if (val >= 32'd3 && val <= 32'd5)
                    begin
                        nx = POS_CHANGE_DIR;
                    end
                    else if (val == 32'd6)
                    begin
                        nx = POS_MAP_UNITS;
                    end
                    else
                    begin
                        nx = POS_L0_ACTIVE;
                    end
                end
                POS_CHANGE_RATE:
                begin
                    nx = POS_L0_ACTIVE;
                end
                POS_MAP_UNITS:
                begin
                    loop_next = val;
                    nx = P_GROUP;
                end
                P_RUN, P_GROUP, P_BRIGHT:
                begin
                    if (loop_reg == 32'd0)
                    begin
                        nx = POS_L0_ACTIVE;
                    end
                    else
                    begin
                        loop_next = loop_reg - 32'd1;
                        nx = (pos_e == P_BRIGHT) ? P_TLEFT : pos_e;
                    end
                end
                P_TLEFT:
                begin
                    nx = P_BRIGHT;
                end
                POS_SLICE_PPS:
                begin
                    bad = (v16 != ac_pps_id_reg) || (ac_pps_sps_reg != ac_sps_id_reg);
                    nx = ac_sep_reg ? POS_COLOUR : POS_FRAME_NUM;
                end
                default:
                begin
                    nx = (pos_e < P_DONE) ? pos_e + 6'd1 : P_DONE;
                end
            endcase

            // enter the next element
            nx_code  = elem_code(nx);
            fw       = {1'b0, ac_log2_reg} + 9'd4;
            pos_next = nx;
            pz_next  = 6'd0;
            acc_next = 32'd0;
            if (nx_code >= K_FIX)
            begin
                bl_next = fixed_bits(nx_code);
            end
            else if (nx_code == K_FRAME)
            begin
                bl_next = (fw > VB9) ? VB6 : fw[5:0];
            end
            else if (nx_code == K_GROUP)
            begin
                bl_next = (flags_next[7:2] == 6'd0) ? 6'd1 : flags_next[7:2];
            end
            else
            begin
                bl_next = 6'd0;
            end
        end
        else
        begin
            nx_code = K_NONE;
            fw      = 9'd0;
        end

        res_v        = fin && (pos_e >= POS_AUD_TYPE) && (pos_e <= POS_FRAME_NUM);
        end_of_entry = q_entry.drop || (bit_reg == 3'd7);

        // commit the sets and restart at unit end
        if (q_entry.last && end_of_entry)
        begin
            if (flags_next[1:0] == KIND_SPS)
            begin
                ac_sps_id_next = pd_sps_id_next;
                ac_log2_next   = pd_log2_next;
                ac_sep_next    = pd_sep_next;
            end
            if (flags_next[1:0] == KIND_PPS)
            begin
                ac_pps_id_next  = pd_pps_id_next;
                ac_pps_sps_next = pd_pps_sps_next;
            end
            pos_next        = '0;
            pz_next         = 6'd0;
            acc_next        = 32'd0;
            bl_next         = 6'd0;
            list_next       = 4'd0;
            ent_next        = 7'd0;
            ls_next         = 8'd8;
            loop_next       = 32'd0;
            flags_next      = 8'd0;
            pd_sps_id_next  = 16'd0;
            pd_log2_next    = 8'd0;
            pd_sep_next     = 1'b0;
            pd_pps_id_next  = 16'd0;
            pd_pps_sps_next = 16'd0;
        end
    end

    // hold stage and output register
    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        extra    = res_v && held_valid_reg;

        state_we        = 1'b0;
        q_pop           = 1'b0;
        bit_next        = bit_reg;
        flush_next      = flush_reg;
        held_valid_next = held_valid_reg;
        held_id_next    = held_id_reg;
        held_value_next = held_value_reg;
        held_bad_next   = held_bad_reg;
        held_err_next   = held_err_reg;
        out_valid_next  = out_valid_reg && out_stall;
        id_next         = id_reg;
        value_next      = value_reg;
        bad_next        = bad_reg;
        err_next        = err_reg;
        last_next       = last_reg;

        if (flush_reg)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                id_next         = held_id_reg;
                value_next      = held_value_reg;
                bad_next        = held_bad_reg;
                err_next        = held_err_reg;
                last_next       = 1'b1;
                held_valid_next = 1'b0;
                flush_next      = 1'b0;
            end
        end
        else if (q_valid && !(extra && !out_free))
        begin
            state_we = 1'b1;
            if (end_of_entry)
            begin
                q_pop    = 1'b1;
                bit_next = 3'd0;
            end
            else
            begin
                bit_next = bit_reg + 3'd1;
            end

            if (extra)
            begin
                // push the older result out, hold the new one
                out_valid_next  = 1'b1;
                id_next         = held_id_reg;
                value_next      = held_value_reg;
                bad_next        = held_bad_reg;
                err_next        = held_err_reg;
                last_next       = 1'b0;
                held_id_next    = 6'(pos_e - 6'd1);
                held_value_next = val;
                held_bad_next   = bad;
                held_err_next   = err;
                if (end_of_entry)
                begin
                    flush_next = 1'b1;
                end
            end
            else if (res_v)
            begin
                if (end_of_entry && out_free)
                begin
                    out_valid_next = 1'b1;
                    id_next        = 6'(pos_e - 6'd1);
                    value_next     = val;
                    bad_next       = bad;
                    err_next       = err;
                    last_next      = 1'b1;
                end
                else
                begin
                    held_valid_next = 1'b1;
                    held_id_next    = 6'(pos_e - 6'd1);
                    held_value_next = val;
                    held_bad_next   = bad;
                    held_err_next   = err;
                    flush_next      = end_of_entry;
                end
            end
            else if (end_of_entry && held_valid_reg)
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    id_next         = held_id_reg;
                    value_next      = held_value_reg;
                    bad_next        = held_bad_reg;
                    err_next        = held_err_reg;
                    last_next       = 1'b1;
                    held_valid_next = 1'b0;
                end
                else
                begin
                    flush_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            pz_reg         <= 6'd0;
            acc_reg        <= 32'd0;
            bl_reg         <= 6'd0;
            list_reg       <= 4'd0;
            ent_reg        <= 7'd0;
            ls_reg         <= 8'd8;
            loop_reg       <= 32'd0;
            flags_reg      <= 8'd0;
            pd_sps_id_reg  <= 16'd0;
            pd_log2_reg    <= 8'd0;
            pd_sep_reg     <= 1'b0;
            pd_pps_id_reg  <= 16'd0;
            pd_pps_sps_reg <= 16'd0;
            ac_sps_id_reg  <= 16'd0;
            ac_log2_reg    <= 8'd0;
            ac_sep_reg     <= 1'b0;
            ac_pps_id_reg  <= 16'd0;
            ac_pps_sps_reg <= 16'd0;
            bit_reg        <= 3'd0;
            flush_reg      <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (state_we)
            begin
                pos_reg        <= pos_next;
                pz_reg         <= pz_next;
                acc_reg        <= acc_next;
                bl_reg         <= bl_next;
                list_reg       <= list_next;
                ent_reg        <= ent_next;
                ls_reg         <= ls_next;
                loop_reg       <= loop_next;
                flags_reg      <= flags_next;
                pd_sps_id_reg  <= pd_sps_id_next;
                pd_log2_reg    <= pd_log2_next;
                pd_sep_reg     <= pd_sep_next;
                pd_pps_id_reg  <= pd_pps_id_next;
                pd_pps_sps_reg <= pd_pps_sps_next;
                ac_sps_id_reg  <= ac_sps_id_next;
                ac_log2_reg    <= ac_log2_next;
                ac_sep_reg     <= ac_sep_next;
                ac_pps_id_reg  <= ac_pps_id_next;
                ac_pps_sps_reg <= ac_pps_sps_next;
            end
            bit_reg        <= bit_next;
            flush_reg      <= flush_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_id_reg    <= held_id_next;
        held_value_reg <= held_value_next;
        held_bad_reg   <= held_bad_next;
        held_err_reg   <= held_err_next;
        id_reg         <= id_next;
        value_reg      <= value_next;
        bad_reg        <= bad_next;
        err_reg        <= err_next;
        last_reg       <= last_next;
    end

    `ASSERT_IMPLY(a_flush_has_held, clk, rst_n, flush_reg, held_valid_reg)
    `ASSERT_IMPLY(a_mid_byte_entry, clk, rst_n, bit_reg != 3'd0, q_valid && !q_entry.drop)
    `ASSERT_IMPLY(a_bad_only_on_ref, clk, rst_n, out_valid_reg && bad_reg, id_reg == FIELD_SLICE_PPS)

endmodule

/* rtl/h264_header_syntax_parser_unit.sv */
// ----------------------------------------------------------------------------
// h264_header_syntax_parser_unit
// H.264 delimiter, sequence set, picture set and slice header field parser.
// ----------------------------------------------------------------------------
// Feed NAL payload bytes (header byte removed) tagged with the unit kind and
// mark the final byte of each unit with last_byte. Each syntax element
// outside the scaling lists and loops comes out as one result: field_id
// numbers the elements in syntax order, values of signed elements are two's
// complement. The parser works one bit per cycle while a request is queued
// and the parser is not held. A byte whose last result cannot go straight
// to the output (an earlier result of the same byte is still held, or the
// output is stalled) needs a flush step, after any output stall clears, to
// hand that result over. A result that completes while another is held and
// the output is stalled holds the parser until the output frees. A dropped
// emulation-prevention byte is popped unparsed. A two-request queue sits
// between the byte front end and the bit parser, so input is taken while
// the parser works and while a result waits at the output. Sequence and
// picture set identifiers and the frame number width commit when the unit's
// last byte has been parsed; a slice header stops after the frame number.
// ----------------------------------------------------------------------------
module h264_header_syntax_parser_unit
    import hhsp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  field_id,
    output logic [31:0] field_value,
    output logic        bad_reference,
    output logic        code_error,
    output logic        last_in_item
);

    hhsp_entry_t push_entry;
    hhsp_entry_t head_entry;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;

    // classify bytes: drop emulation-prevention bytes, keep the unit tag
    hhsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    // decouple byte intake from bit parsing
    hhsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (head_entry)
    );

    // parse bits, emit fields, commit parameter sets
    hhsp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (head_entry),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .field_id      (field_id),
        .field_value   (field_value),
        .bad_reference (bad_reference),
        .code_error    (code_error),
        .last_in_item  (last_in_item)
    );

endmodule

/* tb/tb_h264_header_syntax_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_h264_header_syntax_parser_unit
// Self-checking bench for the H.264 header field parser. Encodes delimiter,
// sequence set, picture set and slice units bit by bit, with emulation bytes
// inserted, and mixes in noise units. A behavioral field predictor computes
// the expected result stream per accepted request, and a monitor compares
// every delivered field in order under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_h264_header_syntax_parser_unit;
    import hhsp_pkg::*;

    localparam bit [4:0] F1 = K_FIX + 5'd1;
    localparam bit [4:0] F2 = K_FIX + 5'd2;
    localparam bit [4:0] F3 = K_FIX + 5'd3;
    localparam bit [4:0] F4 = K_FIX + 5'd4;
    localparam bit [4:0] F8 = K_FIX + 5'd8;
    localparam int NUM_POS = 60;
    localparam int WIDE = 32;

    // element coding per syntax position
    localparam bit [4:0] CODE_OF [NUM_POS] = '{
        K_NONE, F3, F8, F1, F1, F1, F1, F4, F8, K_UE,
        K_UE, F1, K_UE, K_UE, F1, F1, K_UE, K_UE, K_UE, F1,
        K_SE, K_SE, K_UE, K_UE, F1, K_UE, K_UE, F1, K_UE, K_UE,
        F1, F1, K_UE, K_UE, F1, K_UE, K_UE, K_UE, K_UE, F1,
        F2, K_SE, K_SE, K_SE, F1, F1, F1, K_UE, K_UE, K_UE,
        F2, K_FRAME, F1, K_SE, K_SE, K_UE, K_UE, K_UE, K_GROUP, K_NONE
    };

    typedef struct {
        bit [1:0] kind;
        bit [7:0] data;
        bit       last;
    } byte_req_t;

    typedef struct {
        bit [5:0]  id;
        bit [31:0] value;
        bit        bad;
        bit        err;
        bit        last;
    } field_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = '0;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [5:0]  field_id;
    logic [31:0] field_value;
    logic        bad_reference;
    logic        code_error;
    logic        last_in_item;

    h264_header_syntax_parser_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .field_id      (field_id),
        .field_value   (field_value),
        .bad_reference (bad_reference),
        .code_error    (code_error),
        .last_in_item  (last_in_item)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Field predictor state
    // ------------------------------------------------------------------
    int        pr_pos, pr_zeros, pr_prefix, pr_left, pr_list, pr_entry, pr_count;
    bit [31:0] pr_acc, pr_loop;
    bit [7:0]  pr_last_scale, pr_next_scale, pr_flags;
    bit [63:0] pr_pending, pr_active;

    field_t    exp_fields[$];
    byte_req_t byte_reqs[$];
    int        mismatches = 0;

    function automatic bit [63:0] clip(bit [31:0] v, bit [31:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic void put_pending(bit [63:0] v, int shift, bit [63:0] fmask);
        pr_pending = (pr_pending & ~(fmask << shift)) | ((v & fmask) << shift);
    endfunction

    // load the next element: reset the accumulator and set its bit count
    function automatic void enter_pos(int p);
        bit [4:0] c;
        int       w;
        c = CODE_OF[p];
        pr_pos = p;
        pr_prefix = 0;
        pr_acc = '0;
        pr_left = 0;
        if (c >= K_FIX) begin
            pr_left = c - K_FIX;
        end
        else if (c == K_FRAME) begin
            w = pr_active[23:16] + 4;
            pr_left = (w > WIDE) ? WIDE : w;
        end
        else if (c == K_GROUP) begin
            pr_left = pr_flags[7:2];
            if (pr_left == 0)
                pr_left = 1;
        end
    endfunction

    function automatic int next_list();
        pr_list = (pr_list + 1) & 15;
        return (pr_list < (pr_flags[3] ? 12 : 8)) ? P_LIST : POS_LOG2_FN;
    endfunction

    function automatic int loop_on(int again, int after);
        if (pr_loop == 0)
            return after;
        pr_loop = pr_loop - 1;
        return again;
    endfunction

    // syntax walk: next position after element p finished with value v
    function automatic int next_pos(int p, bit [31:0] v, output bit bad);
        int s;
        int size;
        bad = 1'b0;
        case (p)
            POS_AUD_TYPE, POS_FRAME_MBS, POS_REDUNDANT, POS_FRAME_NUM:
                return P_DONE;
            POS_PROFILE:
            begin
                if (v == 100 || v == 110 || v == 122 || v == 144)
                    pr_flags |= 8'd4;
                return POS_CONSTR0;
            end
            POS_SPS_ID:
            begin
                put_pending(clip(v, 32'hFFFF), 0, 64'hFFFF);
                return pr_flags[2] ? POS_CHROMA : POS_LOG2_FN;
            end
            POS_CHROMA:
            begin
                if (v == 3)
                    pr_flags |= 8'd8;
                return (v == 3) ? POS_SEP_PLANE : POS_LUMA_DEPTH;
            end
            POS_SEP_PLANE:
            begin
                put_pending(v & 1, 24, 64'h1);
                return POS_LUMA_DEPTH;
            end
            POS_SCALE_FLAG:
            begin
                if (v == 0)
                    return POS_LOG2_FN;
                pr_list = 0;
                return P_LIST;
            end
            P_LIST:
            begin
                if (v == 0)
                    return next_list();
                pr_entry = 0;
                pr_last_scale = 8'd8;
                pr_next_scale = 8'd8;
                return P_DELTA;
            end
            P_DELTA:
            begin
                size = (pr_list < 6) ? 16 : 64;
                pr_next_scale = pr_last_scale + v[7:0];
                if (pr_next_scale != 0)
                    pr_last_scale = pr_next_scale;
                pr_entry = (pr_entry + 1) & 127;
                return (pr_next_scale == 0 || pr_entry >= size) ? next_list() : P_DELTA;
            end
            POS_LOG2_FN:
            begin
                put_pending(clip(v, 32'hFF), 16, 64'hFF);
                return POS_POC_TYPE;
            end
            POS_POC_TYPE:
                return (v == 0) ? POS_LOG2_POC : ((v == 1) ? POS_POC_ZERO : POS_NUM_REF);
            POS_LOG2_POC:
                return POS_NUM_REF;
            POS_NUM_CYCLE:
            begin
                if (v == 0)
                    return POS_NUM_REF;
                pr_loop = v - 1;
                return P_REFOFS;
            end
            P_REFOFS:
                return loop_on(P_REFOFS, POS_NUM_REF);
            POS_PPS_ID:
            begin
                put_pending(clip(v, 32'hFFFF), 32, 64'hFFFF);
                return POS_PPS_SPS;
            end
            POS_PPS_SPS:
            begin
                put_pending(clip(v, 32'hFFFF), 48, 64'hFFFF);
                return POS_PPS_SPS + 1;
            end
            POS_NUM_GROUPS:
            begin
                // bits per slice group id: ceil(log2(groups))
                s = 0;
                while (s < 32 && (64'd1 << s) < {32'd0, v} + 64'd1)
                    s++;
                pr_flags = (pr_flags & 8'd3) | 8'(s << 2);
                pr_loop = v;
                return (v > 0) ? POS_MAP_TYPE : POS_L0_ACTIVE;
            end
            POS_MAP_TYPE:
            begin
                if (v == 0)
                    return P_RUN;
                if (v == 2)
                begin
                    pr_loop = pr_loop - 1;
                    return P_TLEFT;
                end
                if (v >= 3 && v <= 5)
                    return POS_CHANGE_DIR;
                if (v == 6)
                    return POS_MAP_UNITS;
                return POS_L0_ACTIVE;
            end
            POS_CHANGE_RATE:
                return POS_L0_ACTIVE;
            POS_MAP_UNITS:
            begin
                pr_loop = v;
                return P_GROUP;
            end
            P_RUN:
                return loop_on(P_RUN, POS_L0_ACTIVE);
            P_GROUP:
                return loop_on(P_GROUP, POS_L0_ACTIVE);
            P_TLEFT:
                return P_BRIGHT;
            P_BRIGHT:
                return loop_on(P_TLEFT, POS_L0_ACTIVE);
            POS_SLICE_PPS:
            begin
                bad = (clip(v, 32'hFFFF) != pr_active[47:32])
                      || (pr_active[63:48] != pr_active[15:0]);
                return pr_active[24] ? POS_COLOUR : POS_FRAME_NUM;
            end
            default:
                return (p < P_DONE) ? p + 1 : P_DONE;
        endcase
    endfunction

    function automatic void close_element(int p, bit [31:0] val, bit err);
        bit     bad;
        int     nx;
        field_t f;
        nx = next_pos(p, val, bad);
        if (p >= 1 && p <= 51 && pr_count < 8)
        begin
            f.id = 6'(p - 1);
            f.value = val;
            f.bad = bad;
            f.err = err;
            f.last = 1'b0;
            exp_fields.push_back(f);
            pr_count++;
        end
        enter_pos(nx);
    endfunction

    function automatic void parse_bit(bit b);
        int        p;
        bit [4:0]  c;
        bit [63:0] k;
        bit [31:0] h;
        p = (pr_pos < NUM_POS) ? pr_pos : P_DONE;
        c = CODE_OF[p];
        if (c == K_NONE)
            return;
        if (c != K_UE && c != K_SE)
        begin
            pr_acc = {pr_acc[30:0], b};
            pr_left--;
            if (pr_left == 0)
                close_element(p, pr_acc, 1'b0);
            return;
        end
        if (pr_left == 0)
        begin
            if (!b)
            begin
                pr_prefix++;
                if (pr_prefix < WIDE)
                    return;
                // overlong code: saturate and flag
                close_element(p, (c == K_SE) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF, 1'b1);
                return;
            end
            if (pr_prefix != 0)
            begin
                pr_left = pr_prefix;
                return;
            end
            k = '0;
        end
        else
        begin
            pr_acc = {pr_acc[30:0], b};
            pr_left--;
            if (pr_left != 0)
                return;
            k = ((64'd1 << pr_prefix) - 1) + pr_acc;
        end
        if (c == K_SE)
        begin
            h = 32'((k + 1) >> 1);
            close_element(p, k[0] ? h : -h, 1'b0);
        end
        else
        begin
            close_element(p, k[31:0], 1'b0);
        end
    endfunction

    function automatic void clear_unit();
        pr_pos = 0; pr_zeros = 0; pr_prefix = 0; pr_acc = '0; pr_left = 0;
        pr_list = 0; pr_entry = 0; pr_last_scale = 8'd8; pr_next_scale = 8'd8;
        pr_loop = '0; pr_flags = '0; pr_pending = '0;
    endfunction

    // one accepted request: expected fields go to exp_fields
    function automatic void parse_byte(byte_req_t r);
        int start [4];
        start = '{POS_AUD_TYPE, POS_PROFILE, POS_PPS_ID, POS_FIRST_MB};
        pr_count = 0;
        if (pr_pos == 0)
        begin
            pr_flags = {6'd0, r.kind};
            enter_pos(start[r.kind]);
        end
        if (pr_zeros == 2 && r.data == 8'h03)
        begin
            pr_zeros = 0;
        end
        else
        begin
            pr_zeros = (r.data == 0) ? ((pr_zeros < 2) ? pr_zeros + 1 : 2) : 0;
            for (int i = 7; i >= 0; i--)
                parse_bit(r.data[i]);
        end
        if (pr_count > 0)
            exp_fields[exp_fields.size() - 1].last = 1'b1;
        if (r.last)
        begin
            if (pr_flags[1:0] == KIND_SPS)
                pr_active[24:0] = pr_pending[24:0];
            if (pr_flags[1:0] == KIND_PPS)
                pr_active[63:32] = pr_pending[63:32];
            clear_unit();
        end
    endfunction

    // ------------------------------------------------------------------
    // Bitstream writer for stimulus
    // ------------------------------------------------------------------
    bit unit_bits[$];

    task automatic put_bits(bit [31:0] v, int n);
        for (int i = n - 1; i >= 0; i--)
            unit_bits.push_back(v[i]);
    endtask

    task automatic put_ue(bit [31:0] v);
        bit [32:0] k;
        int        n;
        k = {1'b0, v} + 33'd1;
        n = 0;
        while (n < 32 && (k >> (n + 1)) != 0)
            n++;
        repeat (n) unit_bits.push_back(1'b0);
        for (int i = n; i >= 0; i--)
            unit_bits.push_back(k[i]);
    endtask

    task automatic put_se(int s);
        put_ue((s > 0) ? 2 * s - 1 : -2 * s);
    endtask

    function automatic bit [31:0] rand_id();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(65530, 70000)
                                              : $urandom_range(0, 2);
    endfunction

    // close the unit: stop bit, align, escape start-code patterns, queue bytes
    task automatic flush_unit(bit [1:0] kind, bit cut);
        bit [7:0]  b;
        byte_req_t r;
        int        zc, nbytes;
        unit_bits.push_back(1'b1);
        while (unit_bits.size() % 8 != 0)
            unit_bits.push_back(1'b0);
        nbytes = unit_bits.size() / 8;
        if (cut)
            nbytes = $urandom_range(1, nbytes);
        zc = 0;
        for (int i = 0; i < nbytes; i++)
        begin
            for (int j = 0; j < 8; j++)
                b[7 - j] = unit_bits[8 * i + j];
            r.kind = kind;
            r.last = 1'b0;
            if (zc == 2 && b <= 8'h03)
            begin
                r.data = 8'h03;
                byte_reqs.push_back(r);
                zc = 0;
            end
            r.data = b;
            r.last = (i == nbytes - 1);
            byte_reqs.push_back(r);
            zc = (b == 0) ? ((zc < 2) ? zc + 1 : 2) : 0;
        end
        unit_bits.delete();
    endtask

    task automatic push_raw(bit [1:0] kind, bit [7:0] b, bit last);
        byte_req_t r;
        r.kind = kind;
        r.data = b;
        r.last = last;
        byte_reqs.push_back(r);
    endtask

    task automatic write_scaling(int lists);
        int        size;
        int        d;
        bit [7:0]  lastv, nxt;
        for (int l = 0; l < lists; l++)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                put_bits(0, 1);
                continue;
            end
            put_bits(1, 1);
            size = (l < 6) ? 16 : 64;
            lastv = 8'd8;
            for (int e = 0; e < size; e++)
            begin
                d = ($urandom_range(0, 11) == 0) ? -int'(lastv) : $urandom_range(0, 16) - 8;
                put_se(d);
                nxt = lastv + 8'(d);
                if (nxt == 0)
                    break;
                lastv = nxt;
            end
        end
    endtask

    task automatic gen_sps(bit high, int chroma, bit scaling, int poc, bit cut);
        int pv[4];
        int n;
        pv = '{100, 110, 122, 144};
        put_bits(high ? pv[$urandom_range(0, 3)] : $urandom_range(0, 99), 8);
        put_bits($urandom, 8);
        put_bits($urandom, 8);
        put_ue(rand_id());
        if (high)
        begin
            put_ue(chroma);
            if (chroma == 3)
                put_bits($urandom, 1);
            put_ue($urandom_range(0, 6));
            put_ue($urandom_range(0, 6));
            put_bits($urandom, 1);
            put_bits(scaling, 1);
            if (scaling)
                write_scaling((chroma == 3) ? 12 : 8);
        end
        put_ue(($urandom_range(0, 15) == 0) ? $urandom_range(12, 300) : $urandom_range(0, 12));
        put_ue(poc);
        if (poc == 0)
        begin
            put_ue($urandom_range(0, 12));
        end
        else if (poc == 1)
        begin
            put_bits($urandom, 1);
            put_se($urandom_range(0, 2000) - 1000);
            put_se($urandom_range(0, 2000) - 1000);
            n = $urandom_range(0, 3);
            put_ue(n);
            repeat (n) put_se($urandom_range(0, 64) - 32);
        end
        put_ue($urandom_range(0, 16));
        put_bits($urandom, 1);
        put_ue($urandom_range(0, 120));
        put_ue($urandom_range(0, 68));
        put_bits($urandom, 1);
        flush_unit(KIND_SPS, cut);
    endtask

    task automatic gen_pps(int groups, int map, bit cut);
        int s, m;
        put_ue(rand_id());
        put_ue(rand_id());
        put_bits($urandom, 2);
        put_ue(groups);
        if (groups > 0)
        begin
            put_ue(map);
            if (map == 0)
            begin
                repeat (groups + 1) put_ue($urandom_range(0, 40));
            end
            else if (map == 2)
            begin
                repeat (groups) begin put_ue($urandom_range(0, 99)); put_ue($urandom_range(0, 99)); end
            end
            else if (map >= 3 && map <= 5)
            begin
                put_bits($urandom, 1);
                put_ue($urandom_range(0, 30));
            end
            else if (map == 6)
            begin
                s = 0;
                while ((1 << s) < groups + 1)
                    s++;
                m = $urandom_range(0, 4);
                put_ue(m);
                repeat (m + 1) put_bits($urandom, (s == 0) ? 1 : s);
            end
        end
        put_ue($urandom_range(0, 31));
        put_ue($urandom_range(0, 31));
        put_bits($urandom, 3);
        put_se($urandom_range(0, 50) - 25);
        put_se($urandom_range(0, 50) - 25);
        put_se($urandom_range(0, 24) - 12);
        put_bits($urandom, 3);
        flush_unit(KIND_PPS, cut);
    endtask

    task automatic gen_slice(bit cut);
        put_ue($urandom_range(0, 8000));
        put_ue($urandom_range(0, 9));
        put_ue(rand_id());
        put_bits($urandom, 2 + $urandom_range(0, 1));
        put_bits($urandom, 32);
        flush_unit(KIND_SLICE, cut);
    endtask

    // random bytes, random length, kind changing inside the unit
    task automatic gen_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            push_raw($urandom_range(0, 3), ($urandom_range(0, 3) == 0) ? 8'h00 : $urandom,
                     i == n - 1);
    endtask

    // ------------------------------------------------------------------
    // Driver: present requests at the falling edge, predict on acceptance
    // ------------------------------------------------------------------
    bit presenting = 1'b0;
    bit src_quiet = 1'b0;
    bit snk_quiet = 1'b0;
    int src_wait = 0;
    int snk_wait = 0;
    byte_req_t cur_req;

    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 15) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    // take the request the block accepted at this edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            parse_byte(cur_req);
            presenting <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !presenting)
        begin
            if (src_wait > 0 || byte_reqs.size() == 0)
            begin
                if (src_wait > 0)
                    src_wait <= src_wait - 1;
                in_valid <= 1'b0;
            end
            else
            begin
                // advance to the next request; valid stays up with no gap
                cur_req = byte_reqs.pop_front();
                op <= cur_req.kind;
                data_byte <= cur_req.data;
                last_byte <= cur_req.last;
                in_valid <= 1'b1;
                presenting <= 1'b1;
                src_wait <= draw_wait(src_quiet);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each delivered field with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        field_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            snk_wait <= draw_wait(snk_quiet);
            if (exp_fields.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected field id=%0d value=%h", field_id, field_value);
            end
            else
            begin
                want = exp_fields.pop_front();
                if (field_id !== want.id || field_value !== want.value
                    || bad_reference !== want.bad || code_error !== want.err
                    || last_in_item !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp id=%0d val=%h bad=%b err=%b last=%b,",
                                  " got id=%0d val=%h bad=%b err=%b last=%b"},
                                 want.id, want.value, want.bad, want.err, want.last,
                                 field_id, field_value, bad_reference, code_error,
                                 last_in_item);
                end
            end
        end
    end

    // hold the output stalled while the drawn wait counts down
    always @(negedge clk)
    begin
        out_stall <= (snk_wait != 0);
        if (snk_wait > 0)
            snk_wait <= snk_wait - 1;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int goal, kind;
        clear_unit();
        pr_active = '0;

        // directed: delimiter, high-profile sequence set with 4:4:4 and
        // scaling lists, picture sets with group map styles 6, 2 and 0, slices
        gen_noise();
        put_bits(3'b101, 3);
        flush_unit(KIND_AUD, 1'b0);
        gen_sps(1'b1, 3, 1'b1, 1, 1'b0);
        gen_pps(3, 6, 1'b0);
        gen_slice(1'b0);
        gen_pps(2, 2, 1'b0);
        gen_pps(1, 0, 1'b0);
        gen_sps(1'b0, 0, 1'b0, 0, 1'b0);
        gen_slice(1'b0);
        // overlong Exp-Golomb code in a slice header
        for (int i = 0; i < 5; i++)
            push_raw(KIND_SLICE, 8'h00, 1'b0);
        push_raw(KIND_SLICE, 8'hFF, 1'b1);
        // emulation-prevention byte as the unit's last byte
        push_raw(KIND_PPS, 8'hFF, 1'b0);
        push_raw(KIND_PPS, 8'h00, 1'b0);
        push_raw(KIND_PPS, 8'h00, 1'b0);
        push_raw(KIND_PPS, 8'h03, 1'b1);
        // truncated units commit partial values
        gen_sps(1'b1, 1, 1'b0, 2, 1'b1);
        gen_pps(0, 0, 1'b1);

        // random: mostly well-formed units with random content
        goal = byte_reqs.size() + 20;
        while (byte_reqs.size() < goal)
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: gen_sps($urandom, $urandom_range(0, 3), $urandom_range(0, 3) == 0,
                              $urandom_range(0, 3), $urandom_range(0, 7) == 0);
                2, 3: gen_pps(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 7),
                              $urandom_range(0, 7), $urandom_range(0, 7) == 0);
                4, 5, 6: gen_slice($urandom_range(0, 7) == 0);
                7:
                begin
                    put_bits($urandom, 3);
                    flush_unit(KIND_AUD, 1'b0);
                end
                default: gen_noise();
            endcase
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (byte_reqs.size() != 0 || presenting || exp_fields.size() != 0)
            @(posedge clk);
        // let any trailing result surface
        repeat (100) @(posedge clk);
        if (mismatches == 0 && exp_fields.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
